[hw/rtl/pzw_pkg.sv]
// Shared types, constants and helper functions for the pixel replication zoom window.
// No dependencies; every other file of the block but pzw_queue imports this package.
package pzw_pkg;

  // Fixed field widths of the ports.
  localparam int ZOOM_W      = 5;
  localparam int CENTER_W    = 12;
  localparam int SIZE_W      = 13;
  localparam int DATA_W      = 13;
  localparam int INDEX_W     = 3;
  localparam int PIXEL_W     = 32;
  localparam int OUT_COORD_W = 12;

  // Geometry limits.
  localparam int MAX_ZOOM   = 16;
  localparam int COORD_BITS = 12;
  localparam int VIEW_W     = COORD_BITS + 1;
  localparam int CNT_W      = COORD_BITS;
  localparam int ORIGIN_W   = COORD_BITS + 2;

  // Defaults for the top level parameters.
  localparam int BYTES_PER_PIXEL_DEF = 4;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Reset values of the configuration registers.
  localparam logic [ZOOM_W-1:0] ZOOM_RESET     = ZOOM_W'(4);
  localparam logic [SIZE_W-1:0] SCREEN_W_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SCREEN_H_RESET = SIZE_W'(768);
  localparam logic [SIZE_W-1:0] VIEW_W_RESET   = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] VIEW_H_RESET   = SIZE_W'(256);

  typedef enum logic [INDEX_W-1:0] {
    REG_ZOOM     = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_SCREEN_W = 3'd3,
    REG_SCREEN_H = 3'd4,
    REG_VIEW_W   = 3'd5,
    REG_VIEW_H   = 3'd6
  } reg_index_t;

  // Window geometry as seen by the front and back parts.
  typedef struct packed {
    logic [ZOOM_W-1:0]          zoom;
    logic [VIEW_W-1:0]          view_w;
    logic [VIEW_W-1:0]          view_h;
    logic [SIZE_W-1:0]          screen_w;
    logic [SIZE_W-1:0]          screen_h;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [VIEW_W-1:0]          cols;
    logic [VIEW_W-1:0]          rows;
  } geom_t;

  // One classified source pixel, passed from front to back.
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             done;
  } cmd_t;

  function automatic logic [ZOOM_W-1:0] eff_zoom(input logic [ZOOM_W-1:0] z);
    logic [ZOOM_W-1:0] r;
    r = z;
    if (z == '0) r = ZOOM_W'(1);
    else if (z > ZOOM_W'(MAX_ZOOM)) r = ZOOM_W'(MAX_ZOOM);
    return r;
  endfunction

  function automatic logic [VIEW_W-1:0] eff_view(input logic [SIZE_W-1:0] v);
    logic [VIEW_W-1:0] ve;
    logic [VIEW_W-1:0] r;
    ve = VIEW_W'(v);
    r  = ve;
    if (ve == '0) r = VIEW_W'(1);
    else if (ve > VIEW_W'(1 << COORD_BITS)) r = VIEW_W'(1 << COORD_BITS);
    return r;
  endfunction

endpackage

[hw/rtl/pzw_if.sv]
// Valid/ready channel interfaces for source pixels and fill commands.
// Depends on pzw_pkg for field widths.
interface pzw_in_if;
  import pzw_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] source_pixel;
  logic               frame_start;
  modport source (output valid, source_pixel, frame_start, input ready);
  modport sink   (input valid, source_pixel, frame_start, output ready);
endinterface

interface pzw_out_if;
  import pzw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PIXEL_W-1:0]     fill_value;
  logic [OUT_COORD_W-1:0] dest_x;
  logic [OUT_COORD_W-1:0] dest_y;
  logic [ZOOM_W-1:0]      fill_width;
  logic [ZOOM_W-1:0]      fill_height;
  logic                   window_done;
  modport source (output valid, fill_value, dest_x, dest_y, fill_width, fill_height,
                  window_done, input ready);
  modport sink   (input valid, fill_value, dest_x, dest_y, fill_width, fill_height,
                  window_done, output ready);
endinterface

[hw/rtl/pzw_config.sv]
// Configuration registers and the bit-serial divider that derives window origin and size.
// Depends on pzw_pkg.
module pzw_config (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pzw_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [pzw_pkg::DATA_W-1:0]    cfg_data,
  output pzw_pkg::geom_t                geom,
  output logic                          busy,
  output logic                          restart
);
  import pzw_pkg::*;

  localparam int STEP_W = $clog2(VIEW_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VIEW_W - 1);

  logic [ZOOM_W-1:0]   zoom_factor;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [SIZE_W-1:0]   screen_width;
  logic [SIZE_W-1:0]   screen_height;
  logic [SIZE_W-1:0]   view_width;
  logic [SIZE_W-1:0]   view_height;

  logic hit;
  logic kick;
  logic running;
  logic [STEP_W-1:0] step;

  logic [VIEW_W-1:0] quo_w, quo_h, quo_w_next, quo_h_next;
  logic [ZOOM_W-1:0] rem_w, rem_h, rem_w_next, rem_h_next;
  logic [ZOOM_W:0]   trial_w, trial_h, divisor;
  logic              ge_w, ge_h;

  logic [ZOOM_W-1:0]          z;
  logic [VIEW_W-1:0]          vw, vh;
  logic [VIEW_W-1:0]          cols, rows;
  logic signed [ORIGIN_W-1:0] origin_x, origin_y;

  always_comb begin
    case (cfg_index)
      REG_ZOOM, REG_CENTER_X, REG_CENTER_Y, REG_SCREEN_W,
      REG_SCREEN_H, REG_VIEW_W, REG_VIEW_H: hit = cfg_write;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_factor   <= ZOOM_RESET;
      center_x      <= '0;
      center_y      <= '0;
      screen_width  <= SCREEN_W_RESET;
      screen_height <= SCREEN_H_RESET;
      view_width    <= VIEW_W_RESET;
      view_height   <= VIEW_H_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZOOM:     zoom_factor   <= cfg_data[ZOOM_W-1:0];
        REG_CENTER_X: center_x      <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y: center_y      <= cfg_data[CENTER_W-1:0];
        REG_SCREEN_W: screen_width  <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_H: screen_height <= cfg_data[SIZE_W-1:0];
        REG_VIEW_W:   view_width    <= cfg_data[SIZE_W-1:0];
        REG_VIEW_H:   view_height   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign z  = eff_zoom(zoom_factor);
  assign vw = eff_view(view_width);
  assign vh = eff_view(view_height);

  // One restoring division step per cycle for width and height in parallel.
  always_comb begin
    divisor    = {1'b0, z};
    trial_w    = {rem_w, quo_w[VIEW_W-1]};
    trial_h    = {rem_h, quo_h[VIEW_W-1]};
    ge_w       = trial_w >= divisor;
    ge_h       = trial_h >= divisor;
    rem_w_next = ge_w ? ZOOM_W'(trial_w - divisor) : trial_w[ZOOM_W-1:0];
    rem_h_next = ge_h ? ZOOM_W'(trial_h - divisor) : trial_h[ZOOM_W-1:0];
    quo_w_next = {quo_w[VIEW_W-2:0], ge_w};
    quo_h_next = {quo_h[VIEW_W-2:0], ge_h};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kick    <= 1'b1;
      running <= 1'b0;
    end else begin
      kick <= hit;
      if (kick) begin
        running <= 1'b1;
        step    <= '0;
        quo_w   <= vw;
        quo_h   <= vh;
        rem_w   <= '0;
        rem_h   <= '0;
      end else if (running) begin
        quo_w <= quo_w_next;
        quo_h <= quo_h_next;
        rem_w <= rem_w_next;
        rem_h <= rem_h_next;
        step  <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          running <= 1'b0;
          // Size rounds the quotient up; origin backs off half the view in source pixels.
          cols     <= quo_w_next + VIEW_W'(rem_w_next != '0);
          rows     <= quo_h_next + VIEW_W'(rem_h_next != '0);
          origin_x <= signed'(ORIGIN_W'(center_x)) - signed'(ORIGIN_W'(quo_w_next[VIEW_W-1:1]));
          origin_y <= signed'(ORIGIN_W'(center_y)) - signed'(ORIGIN_W'(quo_h_next[VIEW_W-1:1]));
        end
      end
    end
  end

  assign busy    = hit | kick | running;
  assign restart = hit;

  always_comb begin
    geom.zoom     = z;
    geom.view_w   = vw;
    geom.view_h   = vh;
    geom.screen_w = screen_width;
    geom.screen_h = screen_height;
    geom.origin_x = origin_x;
    geom.origin_y = origin_y;
    geom.cols     = cols;
    geom.rows     = rows;
  end

`ifndef NO_ASSERTIONS
  a_divider_runs_full: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(running) |-> $past(step) == LAST_STEP)
    else $error("geometry divider stopped before its last step");
`endif

endmodule

[hw/rtl/pzw_queue.sv]
// Short first-in first-out queue between the front and back parts.
// Depends on pzw_pkg only through the instantiating module.
module pzw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_push_only_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("queue fill level did not follow a lone push");
`endif

endmodule

[hw/rtl/pzw_front.sv]
// Front part: accepts source pixels, walks the window position and classifies on/off screen.
// Depends on pzw_pkg and pzw_in_if.
module pzw_front #(
  parameter int PIX_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  pzw_in_if.sink            in_ch,
  input  pzw_pkg::geom_t    geom,
  input  logic              busy,
  input  logic              restart,
  output logic              push_valid,
  input  logic              push_ready,
  output pzw_pkg::cmd_t     push_cmd,
  output logic [PIX_W-1:0]  push_pixel
);
  import pzw_pkg::*;

  logic [CNT_W-1:0] col, row, col_next, row_next, cur_col, cur_row;
  logic signed [ORIGIN_W-1:0] sx, sy;
  logic on_screen, last_col, last_row, accept;

  assign in_ch.ready = !busy && push_ready;
  assign push_valid  = in_ch.valid && !busy;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_col  = in_ch.frame_start ? '0 : col;
    cur_row  = in_ch.frame_start ? '0 : row;
    sx       = geom.origin_x + signed'(ORIGIN_W'(cur_col));
    sy       = geom.origin_y + signed'(ORIGIN_W'(cur_row));
    on_screen = !sx[ORIGIN_W-1] && (SIZE_W'(sx[ORIGIN_W-2:0]) < geom.screen_w) &&
                !sy[ORIGIN_W-1] && (SIZE_W'(sy[ORIGIN_W-2:0]) < geom.screen_h);
    last_col = VIEW_W'(cur_col) + VIEW_W'(1) == geom.cols;
    last_row = VIEW_W'(cur_row) + VIEW_W'(1) == geom.rows;
    col_next = last_col ? '0 : cur_col + CNT_W'(1);
    row_next = last_col ? (last_row ? '0 : cur_row + CNT_W'(1)) : cur_row;
    push_cmd.col  = cur_col;
    push_cmd.row  = cur_row;
    push_cmd.done = last_col && last_row;
    push_pixel    = on_screen ? in_ch.source_pixel[PIX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && push_cmd.done |=> col == '0 && row == '0)
    else $error("window position did not wrap after the last pixel");
`endif

endmodule

[hw/rtl/pzw_back.sv]
// Back part: scales the window position, clips the block to the view and holds the result.
// Depends on pzw_pkg and pzw_out_if.
module pzw_back #(
  parameter int PIX_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  pzw_pkg::geom_t    geom,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  pzw_pkg::cmd_t     pop_cmd,
  input  logic [PIX_W-1:0]  pop_pixel,
  pzw_out_if.source         out_ch
);
  import pzw_pkg::*;

  localparam int PROD_W = CNT_W + ZOOM_W;

  logic [PROD_W-1:0] dx, dy, vw_ext, vh_ext, room_x, room_y, z_ext;
  logic [ZOOM_W-1:0] fw, fh;
  logic out_valid, load;

  logic [PIXEL_W-1:0]     fill_value;
  logic [OUT_COORD_W-1:0] dest_x, dest_y;
  logic [ZOOM_W-1:0]      fill_width, fill_height;
  logic                   window_done;

  assign pop_ready = !out_valid || out_ch.ready;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    dx     = PROD_W'(pop_cmd.col) * PROD_W'(geom.zoom);
    dy     = PROD_W'(pop_cmd.row) * PROD_W'(geom.zoom);
    vw_ext = PROD_W'(geom.view_w);
    vh_ext = PROD_W'(geom.view_h);
    z_ext  = PROD_W'(geom.zoom);
    room_x = (vw_ext > dx) ? vw_ext - dx : '0;
    room_y = (vh_ext > dy) ? vh_ext - dy : '0;
    fw     = (room_x > z_ext) ? geom.zoom : room_x[ZOOM_W-1:0];
    fh     = (room_y > z_ext) ? geom.zoom : room_y[ZOOM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fill_value  <= PIXEL_W'(pop_pixel);
      dest_x      <= dx[OUT_COORD_W-1:0];
      dest_y      <= dy[OUT_COORD_W-1:0];
      fill_width  <= fw;
      fill_height <= fh;
      window_done <= pop_cmd.done;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.fill_value  = fill_value;
  assign out_ch.dest_x      = dest_x;
  assign out_ch.dest_y      = dest_y;
  assign out_ch.fill_width  = fill_width;
  assign out_ch.fill_height = fill_height;
  assign out_ch.window_done = window_done;

`ifndef NO_ASSERTIONS
  a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !load)
    else $error("queue entry taken while the output register was stalled");
`endif

endmodule

[hw/rtl/pixel_replication_zoom_window.sv]
// Integer pixel replication zoom of a window centered on a screen point, one fill command a pixel.
// The block accepts one source pixel per clock while not busy and while the queue has room;
// a four-entry queue between the classifying front and the scaling back absorbs output stalls.
// After reset and after every configuration write to one of the seven registers the window
// origin and size are recomputed by a bit-serial divider, one quotient bit a cycle. After a write,
// input is held off for the write cycle, the load cycle and 13 division steps; after reset, for
// the load cycle and the 13 steps. Configuration writes are still taken meanwhile.
// Depends on pzw_pkg, pzw_if, pzw_config, pzw_queue, pzw_front and pzw_back.
module pixel_replication_zoom_window #(
  parameter int BYTES_PER_PIXEL = pzw_pkg::BYTES_PER_PIXEL_DEF,
  parameter int QUEUE_DEPTH     = pzw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  pzw_in_if.sink                       in_ch,
  pzw_out_if.source                    out_ch,
  input  logic                         cfg_write,
  input  logic [pzw_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [pzw_pkg::DATA_W-1:0]   cfg_data
);
  import pzw_pkg::*;

  localparam int PIX_W   = 8 * BYTES_PER_PIXEL;
  localparam int ENTRY_W = $bits(cmd_t) + PIX_W;

  geom_t            geom;
  logic             busy, restart;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  cmd_t             push_cmd, pop_cmd;
  logic [PIX_W-1:0] push_pixel, pop_pixel;
  logic [ENTRY_W-1:0] push_entry, pop_entry;

  pzw_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (busy),
    .restart   (restart)
  );

  pzw_front #(.PIX_W(PIX_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .geom       (geom),
    .busy       (busy),
    .restart    (restart),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_pixel (push_pixel)
  );

  assign push_entry = {push_cmd, push_pixel};
  assign pop_cmd    = pop_entry[ENTRY_W-1:PIX_W];
  assign pop_pixel  = pop_entry[PIX_W-1:0];

  pzw_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_entry)
  );

  pzw_back #(.PIX_W(PIX_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .pop_pixel (pop_pixel),
    .out_ch    (out_ch)
  );

endmodule
